// File: hw/rtl/hsl_to_rgb_converter_top_defines.svh
// assertion macros for the hsl to rgb converter
// used by hsl_to_rgb_converter_top, no other dependencies
`ifndef HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define HSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsl assertion failed");
// checked on every edge, reset included
`define HSL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("hsl assertion failed");
`else
`define HSL_ASSERT(lbl, clk, rst_n, prop)
`define HSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/hsl_pkg.sv
// types and constants shared by the hsl to rgb converter
// no dependencies
package hsl_pkg;

    localparam int unsigned LevelW = 9;
    localparam int unsigned HueW   = 16;
    localparam int unsigned XW     = 17;   // lightness terms, up to 65536
    localparam int unsigned ScaleW = 24;   // 255 * x
    localparam int unsigned ProdW  = 41;   // ramp weight times span

    localparam logic [LevelW-1:0] OneLevel  = 9'd256;
    localparam logic [LevelW-1:0] HalfLevel = 9'd128;

    typedef logic [2:0] t_sector;

    localparam t_sector SecRedGreen   = 3'd0;
    localparam t_sector SecGreenRed   = 3'd1;
    localparam t_sector SecGreenBlue  = 3'd2;
    localparam t_sector SecBlueGreen  = 3'd3;
    localparam t_sector SecBlueRed    = 3'd4;
    localparam t_sector SecRedBlue    = 3'd5;

    typedef struct packed {
        logic              led_index;
        logic [HueW-1:0]   hue_turn;
        logic [LevelW-1:0] sat_level;
        logic [LevelW-1:0] light_level;
    } t_hsl_item;

    typedef struct packed {
        logic        led_index_out;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
        logic [23:0] packed_rgb;
    } t_rgb_item;

    // after stage one: lightness terms and hue split
    typedef struct packed {
        logic            led;
        t_sector         sector;
        logic [HueW-1:0] frac;
        logic [XW-1:0]   x_hi;
        logic [XW-1:0]   x_lo;
    } t_lvl_item;

    // after stage two: scaled max, min, span and ramp weight
    typedef struct packed {
        logic              led;
        t_sector           sector;
        logic [XW-1:0]     weight;
        logic [ScaleW-1:0] hi;
        logic [ScaleW-1:0] lo;
        logic [ScaleW-1:0] span;
    } t_scl_item;

    // after stage three: product and fixed channel levels
    typedef struct packed {
        logic              led;
        t_sector           sector;
        logic [ProdW-1:0]  prod;
        logic [ScaleW-1:0] lo;
        logic [7:0]        hi_lvl;
        logic [7:0]        lo_lvl;
    } t_ramp_item;

endpackage

// File: hw/rtl/hsl_to_rgb_converter_top.sv
// hsl to rgb converter, top level: four-stage pipeline
// depends on hsl_pkg, hsl_levels, hsl_ramp, hsl_mix and the defines header
//
// usage:
//   input channel: i_hsl_valid / o_hsl_stall carry one hsl item (led index,
//   hue as a fraction of a turn, saturation and lightness on 0..256).
//   output channel: o_rgb_valid / i_rgb_stall carry one rgb item (led index,
//   8-bit red, green, blue and the packed 24-bit color).
//   an item moves on an edge where valid is high and stall is low.
//   an accepted item passes the lightness, scale, ramp and output registers.
//   throughput: one item per cycle when not stalled; every stage has its own
//   valid bit and the ramp multiply (17 x 24 bits) owns stage three.
//   a stalled receiver holds the output register; earlier stages keep
//   filling bubbles, and o_hsl_stall rises only once all four stages hold
//   an item.
//   reset empties the pipeline: o_rgb_valid is low on the cycle after it;
//   there is no other state to clear.
`include "hsl_to_rgb_converter_top_defines.svh"
module hsl_to_rgb_converter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hsl_valid,
    output logic               o_hsl_stall,
    input  hsl_pkg::t_hsl_item i_hsl,
    output logic               o_rgb_valid,
    input  logic               i_rgb_stall,
    output hsl_pkg::t_rgb_item o_rgb
);

    logic                lvl_valid;
    logic                lvl_stall;
    hsl_pkg::t_scl_item  lvl_data;
    logic                ramp_valid;
    logic                ramp_stall;
    hsl_pkg::t_ramp_item ramp_data;

    hsl_levels u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_hsl_valid),
        .i_data  (i_hsl),
        .o_stall (o_hsl_stall),
        .o_valid (lvl_valid),
        .o_data  (lvl_data),
        .i_stall (lvl_stall)
    );

    hsl_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lvl_valid),
        .i_data  (lvl_data),
        .o_stall (lvl_stall),
        .o_valid (ramp_valid),
        .o_data  (ramp_data),
        .i_stall (ramp_stall)
    );

    hsl_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ramp_valid),
        .i_data  (ramp_data),
        .o_stall (ramp_stall),
        .o_valid (o_rgb_valid),
        .o_data  (o_rgb),
        .i_stall (i_rgb_stall)
    );

    // pipeline is empty right after reset
    `HSL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_rgb_valid)
    // back pressure only comes from a stalled, occupied output
    `HSL_ASSERT(a_stall_source, i_clk, i_rst_n, o_hsl_stall |-> i_rgb_stall && o_rgb_valid)
    // with no stall an accepted item reaches the output
    `HSL_ASSERT(a_latency, i_clk, i_rst_n, (i_hsl_valid && !o_hsl_stall && !i_rgb_stall) ##1 !i_rgb_stall ##1 !i_rgb_stall ##1 !i_rgb_stall |=> o_rgb_valid)
    // packed color agrees with the channels
    `HSL_ASSERT(a_packed, i_clk, i_rst_n, o_rgb_valid |-> o_rgb.packed_rgb[23:16] == o_rgb.red_level && o_rgb.packed_rgb[15:8] == o_rgb.green_level && o_rgb.packed_rgb[7:0] == o_rgb.blue_level)

endmodule

// File: hw/rtl/hsl_levels.sv
// stages one and two: clamp, channel max and min scaled by 255 with their span, hue sector and weight
// depends on hsl_pkg
module hsl_levels (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsl_pkg::t_hsl_item  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output hsl_pkg::t_scl_item  o_data,
    input  logic                i_stall
);

    logic                r_v1;
    hsl_pkg::t_lvl_item  r_s1;
    hsl_pkg::t_lvl_item  n_s1;
    logic                r_v2;
    hsl_pkg::t_scl_item  r_s2;
    hsl_pkg::t_scl_item  n_s2;
    logic                adv1;
    logic                adv2;

    logic [hsl_pkg::LevelW-1:0] sat;
    logic [hsl_pkg::LevelW-1:0] lit;
    logic [hsl_pkg::XW-1:0]     cross_term;
    logic [18:0]                pos;
    logic [hsl_pkg::XW+7:0]     hi_full;
    logic [hsl_pkg::XW+7:0]     lo_full;

    assign adv2    = !r_v2 || !i_stall;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_comb begin
        sat = (i_data.sat_level > hsl_pkg::OneLevel) ? hsl_pkg::OneLevel : i_data.sat_level;
        lit = (i_data.light_level > hsl_pkg::OneLevel) ? hsl_pkg::OneLevel
                                                       : i_data.light_level;
        // (1-l)*s for the upper half, at most 128*256
        cross_term = 17'(hsl_pkg::OneLevel - lit) * 17'(sat);
        pos        = 19'({i_data.hue_turn, 2'b00}) + 19'({i_data.hue_turn, 1'b0});

        n_s1.led    = i_data.led_index;
        n_s1.sector = pos[18:16];
        n_s1.frac   = pos[15:0];
        if (lit < hsl_pkg::HalfLevel) begin
            n_s1.x_hi = 17'(lit[6:0]) * (17'(hsl_pkg::OneLevel) + 17'(sat));
            n_s1.x_lo = 17'(lit[6:0]) * (17'(hsl_pkg::OneLevel) - 17'(sat));
        end else begin
            n_s1.x_hi = {lit, 8'd0} + cross_term;
            n_s1.x_lo = {lit, 8'd0} - cross_term;
        end
    end

    always_comb begin
        // times 255 as shift and subtract
        hi_full = {r_s1.x_hi, 8'd0} - {8'd0, r_s1.x_hi};
        lo_full = {r_s1.x_lo, 8'd0} - {8'd0, r_s1.x_lo};

        n_s2.led    = r_s1.led;
        n_s2.sector = r_s1.sector;
        n_s2.hi     = hi_full[hsl_pkg::ScaleW-1:0];
        n_s2.lo     = lo_full[hsl_pkg::ScaleW-1:0];
        n_s2.span   = hi_full[hsl_pkg::ScaleW-1:0] - lo_full[hsl_pkg::ScaleW-1:0];
        // odd sectors ramp down
        if (r_s1.sector[0]) begin
            n_s2.weight = 17'h10000 - 17'(r_s1.frac);
        end else begin
            n_s2.weight = 17'(r_s1.frac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) r_s1 <= n_s1;
        if (adv2 && r_v1)    r_s2 <= n_s2;
    end

    assign o_valid = r_v2;
    assign o_data  = r_s2;

endmodule

// File: hw/rtl/hsl_ramp.sv
// stage three: ramp weight times channel span
// depends on hsl_pkg
module hsl_ramp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsl_pkg::t_scl_item  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output hsl_pkg::t_ramp_item o_data,
    input  logic                i_stall
);

    logic                r_v;
    hsl_pkg::t_ramp_item r_s;
    hsl_pkg::t_ramp_item n_s;
    logic                adv;

    assign adv     = !r_v || !i_stall;
    assign o_stall = !adv;

    always_comb begin
        n_s.led    = i_data.led;
        n_s.sector = i_data.sector;
        n_s.prod   = hsl_pkg::ProdW'(i_data.weight) * hsl_pkg::ProdW'(i_data.span);
        n_s.lo     = i_data.lo;
        n_s.hi_lvl = i_data.hi[23:16];
        n_s.lo_lvl = i_data.lo[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) r_s <= n_s;
    end

    assign o_valid = r_v;
    assign o_data  = r_s;

endmodule

// File: hw/rtl/hsl_mix.sv
// stage four: ramp sum and per-sector channel selection into the output register
// depends on hsl_pkg
module hsl_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsl_pkg::t_ramp_item i_data,
    output logic                o_stall,
    output logic                o_valid,
    output hsl_pkg::t_rgb_item  o_data,
    input  logic                i_stall
);

    logic               r_v;
    hsl_pkg::t_rgb_item r_s;
    hsl_pkg::t_rgb_item n_s;
    logic               adv;
    logic [hsl_pkg::ProdW-1:0] acc;
    logic [7:0]         ramp;
    logic [7:0]         red;
    logic [7:0]         grn;
    logic [7:0]         blu;

    assign adv     = !r_v || !i_stall;
    assign o_stall = !adv;

    always_comb begin
        acc  = {1'b0, i_data.lo, 16'd0} + i_data.prod;
        ramp = acc[39:32];
        unique case (i_data.sector)
            hsl_pkg::SecRedGreen: begin
                red = i_data.hi_lvl; grn = ramp;          blu = i_data.lo_lvl;
            end
            hsl_pkg::SecGreenRed: begin
                red = ramp;          grn = i_data.hi_lvl; blu = i_data.lo_lvl;
            end
            hsl_pkg::SecGreenBlue: begin
                red = i_data.lo_lvl; grn = i_data.hi_lvl; blu = ramp;
            end
            hsl_pkg::SecBlueGreen: begin
                red = i_data.lo_lvl; grn = ramp;          blu = i_data.hi_lvl;
            end
            hsl_pkg::SecBlueRed: begin
                red = ramp;          grn = i_data.lo_lvl; blu = i_data.hi_lvl;
            end
            default: begin
                red = i_data.hi_lvl; grn = i_data.lo_lvl; blu = ramp;
            end
        endcase
        n_s.led_index_out = i_data.led;
        n_s.red_level     = red;
        n_s.green_level   = grn;
        n_s.blue_level    = blu;
        n_s.packed_rgb    = {red, grn, blu};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) r_s <= n_s;
    end

    assign o_valid = r_v;
    assign o_data  = r_s;

endmodule
